// ===== design/orc_pkg.sv =====
// Types and constants shared by the oriented rectangle containment pipeline.
package orc_pkg;

  localparam int unsigned CORNERS      = 4;
  localparam int unsigned DOT_W        = 66;
  localparam int unsigned ORIGIN_SHIFT = 14;
  localparam int unsigned LIM_SHIFT    = 28;
  localparam int unsigned IN_TDATA_W   = 320;
  localparam int unsigned OUT_TDATA_W  = 8;

  typedef struct packed {
    logic signed [31:0] cont_origin_x;
    logic signed [31:0] cont_origin_y;
    logic signed [15:0] cont_normal_x;
    logic signed [15:0] cont_normal_y;
    logic        [30:0] cont_width;
    logic        [30:0] cont_thickness;
    logic signed [31:0] obj_origin_x;
    logic signed [31:0] obj_origin_y;
    logic signed [15:0] obj_normal_x;
    logic signed [15:0] obj_normal_y;
    logic        [30:0] obj_width;
    logic        [30:0] obj_thickness;
  } orc_item_t;

  // Origin delta and axis cross-dot terms.
  typedef struct packed {
    logic signed [32:0] ddx;
    logic signed [32:0] ddy;
    logic signed [15:0] cnx;
    logic signed [15:0] cny;
    logic        [30:0] ow;
    logic        [30:0] ot;
    logic signed [32:0] pp;
    logic signed [32:0] pn;
    logic signed [32:0] np;
    logic signed [32:0] nn;
    logic        [30:0] cw;
    logic        [30:0] ct;
  } orc_s1_t;

  // Projected origin partial products and projected edges.
  typedef struct packed {
    logic signed [48:0] bpx;
    logic signed [48:0] bpy;
    logic signed [48:0] bnx;
    logic signed [48:0] bny;
    logic signed [63:0] ewp;
    logic signed [63:0] etp;
    logic signed [63:0] ewn;
    logic signed [63:0] etn;
    logic        [30:0] cw;
    logic        [30:0] ct;
  } orc_s2_t;

  // Corner projections onto the container axes, scale 2^-44.
  typedef struct packed {
    logic [CORNERS-1:0][DOT_W-1:0] proj_p;
    logic [CORNERS-1:0][DOT_W-1:0] proj_n;
    logic [30:0]                   cw;
    logic [30:0]                   ct;
  } orc_s3_t;

endpackage

// ===== design/orc_dir_stage.sv =====
// Stage 1: origin delta and dot products between the two rectangles' axes.
module orc_dir_stage import orc_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  orc_item_t item_i,
  output orc_s1_t   s1_o
);

  orc_s1_t            s1_d, s1_q;
  logic signed [31:0] m_yy, m_xx, m_yx, m_xy;

  always_comb begin
    m_yy = 32'(item_i.cont_normal_y) * 32'(item_i.obj_normal_y);
    m_xx = 32'(item_i.cont_normal_x) * 32'(item_i.obj_normal_x);
    m_yx = 32'(item_i.cont_normal_y) * 32'(item_i.obj_normal_x);
    m_xy = 32'(item_i.cont_normal_x) * 32'(item_i.obj_normal_y);
    s1_d.ddx = 33'(item_i.obj_origin_x) - 33'(item_i.cont_origin_x);
    s1_d.ddy = 33'(item_i.obj_origin_y) - 33'(item_i.cont_origin_y);
    s1_d.cnx = item_i.cont_normal_x;
    s1_d.cny = item_i.cont_normal_y;
    s1_d.ow  = item_i.obj_width;
    s1_d.ot  = item_i.obj_thickness;
    s1_d.pp  = 33'(m_yy) + 33'(m_xx);
    s1_d.pn  = 33'(m_yx) - 33'(m_xy);
    s1_d.np  = 33'(m_xy) - 33'(m_yx);
    s1_d.nn  = 33'(m_xx) + 33'(m_yy);
    s1_d.cw  = item_i.cont_width;
    s1_d.ct  = item_i.cont_thickness;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

// ===== design/orc_mul_stage.sv =====
// Stage 2: origin delta and object edges multiplied onto the container axes.
module orc_mul_stage import orc_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  orc_s1_t s1_i,
  output orc_s2_t s2_o
);

  orc_s2_t            s2_d, s2_q;
  logic signed [31:0] ow_s, ot_s;

  always_comb begin
    ow_s     = $signed({1'b0, s1_i.ow});
    ot_s     = $signed({1'b0, s1_i.ot});
    s2_d.bpx = 49'(s1_i.ddx) * 49'(s1_i.cny);
    s2_d.bpy = 49'(s1_i.ddy) * 49'(s1_i.cnx);
    s2_d.bnx = 49'(s1_i.ddx) * 49'(s1_i.cnx);
    s2_d.bny = 49'(s1_i.ddy) * 49'(s1_i.cny);
    s2_d.ewp = 64'(ow_s) * 64'(s1_i.pp);
    s2_d.etp = 64'(ot_s) * 64'(s1_i.pn);
    s2_d.ewn = 64'(ow_s) * 64'(s1_i.np);
    s2_d.etn = 64'(ot_s) * 64'(s1_i.nn);
    s2_d.cw  = s1_i.cw;
    s2_d.ct  = s1_i.ct;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

// ===== design/orc_corner_stage.sv =====
// Stage 3: projections of the four object corners onto both container axes.
module orc_corner_stage import orc_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  orc_s2_t s2_i,
  output orc_s3_t s3_o
);

  orc_s3_t                   s3_d, s3_q;
  logic signed [DOT_W-1:0]   b_p, b_n, w_p, t_p, w_n, t_n;

  always_comb begin
    b_p = (DOT_W'(s2_i.bpx) - DOT_W'(s2_i.bpy)) <<< ORIGIN_SHIFT;
    b_n = (DOT_W'(s2_i.bnx) + DOT_W'(s2_i.bny)) <<< ORIGIN_SHIFT;
    w_p = DOT_W'(s2_i.ewp);
    t_p = DOT_W'(s2_i.etp);
    w_n = DOT_W'(s2_i.ewn);
    t_n = DOT_W'(s2_i.etn);
    s3_d.proj_p[0] = b_p;
    s3_d.proj_p[1] = b_p + w_p;
    s3_d.proj_p[2] = b_p + w_p + t_p;
    s3_d.proj_p[3] = b_p + t_p;
    s3_d.proj_n[0] = b_n;
    s3_d.proj_n[1] = b_n + w_n;
    s3_d.proj_n[2] = b_n + w_n + t_n;
    s3_d.proj_n[3] = b_n + t_n;
    s3_d.cw        = s2_i.cw;
    s3_d.ct        = s2_i.ct;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;

endmodule

// ===== design/orc_check_stage.sv =====
// Stage 4: bounds check of every corner projection, registered verdict.
module orc_check_stage import orc_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  orc_s3_t s3_i,
  output logic    enclosed_o
);

  logic                    enclosed_d, enclosed_q;
  logic signed [DOT_W-1:0] lim_p, lim_n;
  logic [CORNERS-1:0]      ok_p, ok_n;

  always_comb begin
    lim_p = $signed(DOT_W'(s3_i.cw) << LIM_SHIFT);
    lim_n = $signed(DOT_W'(s3_i.ct) << LIM_SHIFT);
    for (int k = 0; k < CORNERS; k++) begin
      ok_p[k] = !s3_i.proj_p[k][DOT_W-1] && ($signed(s3_i.proj_p[k]) <= lim_p);
      ok_n[k] = !s3_i.proj_n[k][DOT_W-1] && ($signed(s3_i.proj_n[k]) <= lim_n);
    end
    enclosed_d = (&ok_p) & (&ok_n);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      enclosed_q <= enclosed_d;
    end
  end

  assign enclosed_o = enclosed_q;

endmodule

// ===== design/oriented_rect_containment_unit.sv =====
// Oriented rectangle containment unit: top level with pipeline control.
//
// Tests whether an object rectangle lies wholly inside a container rectangle,
// both given as origin corner, Q2.14 normal and UQ15.16 extents, with exact
// arithmetic and inclusive bounds. Four register stages (axis products,
// multiplies, corner sums, bounds check); the last is the output register.
// One pair is accepted every cycle while the first stage is empty or moving on.
// Each stage holds while the one after it is full and stalled, so empty stages
// still take new transfers during an output stall.
module oriented_rect_containment_unit import orc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cont_origin_x, cont_origin_y, cont_normal_x, cont_normal_y, cont_width,
  // cont_thickness, obj_origin_x, obj_origin_y, obj_normal_x, obj_normal_y,
  // obj_width, obj_thickness; zero padded to 320 bits
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // enclosed; zero padded to 8 bits
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned STAGES = 4;

  orc_item_t         item;
  orc_s1_t           s1;
  orc_s2_t           s2;
  orc_s3_t           s3;
  logic              enclosed;
  logic [STAGES-1:0] vld_d, vld_q;
  logic [STAGES:0]   en;

  always_comb begin
    item.cont_origin_x  = $signed(s_axis_tdata[31:0]);
    item.cont_origin_y  = $signed(s_axis_tdata[63:32]);
    item.cont_normal_x  = $signed(s_axis_tdata[79:64]);
    item.cont_normal_y  = $signed(s_axis_tdata[95:80]);
    item.cont_width     = s_axis_tdata[126:96];
    item.cont_thickness = s_axis_tdata[157:127];
    item.obj_origin_x   = $signed(s_axis_tdata[189:158]);
    item.obj_origin_y   = $signed(s_axis_tdata[221:190]);
    item.obj_normal_x   = $signed(s_axis_tdata[237:222]);
    item.obj_normal_y   = $signed(s_axis_tdata[253:238]);
    item.obj_width      = s_axis_tdata[284:254];
    item.obj_thickness  = s_axis_tdata[315:285];
  end

  // en[k] loads stage k; en[STAGES] is the downstream ready.
  always_comb begin
    en[STAGES] = m_axis_tready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = s_axis_tvalid;
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  orc_dir_stage u_dir (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .item_i (item),
    .s1_o   (s1)
  );

  orc_mul_stage u_mul (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  orc_corner_stage u_corner (
    .clk_i (clk_i),
    .en_i  (en[2]),
    .s2_i  (s2),
    .s3_o  (s3)
  );

  orc_check_stage u_check (
    .clk_i      (clk_i),
    .en_i       (en[3]),
    .s3_i       (s3),
    .enclosed_o (enclosed)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[STAGES-1];
  assign m_axis_tdata  = {(OUT_TDATA_W-1)'(0), enclosed};

`ifndef SYNTH
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transfer did not enter stage 1");

  a_bubble_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> s_axis_tready)
    else $error("input blocked with empty first stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STAGES-1] && !m_axis_tready |=> vld_q[STAGES-1] && $stable(enclosed))
    else $error("stalled result lost");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && en[2] |=> vld_q[2])
    else $error("item dropped between stages 2 and 3");
`endif

endmodule
